// ===== design/axis_rect_ray_hit_macros.svh =====
// Assertion macros for the ray against rectangle block.
// Used by axis_rect_ray_hit.sv; expects i_clk and i_rst_n in scope.
`ifndef AXIS_RECT_RAY_HIT_MACROS_SVH
`define AXIS_RECT_RAY_HIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARRH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arrh check failed");

// Next-cycle implication, checked outside reset.
`define ARRH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arrh check failed");

`endif

// ===== design/arrh_pkg.sv =====
// Shared constants and types for the ray against rectangle block.
// No dependencies; imported by every module of the block.
`default_nettype none

package arrh_pkg;

    // Fixed point format of coordinates.
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int TEX_W   = FRAC_W + 1;
    localparam int MAT_W   = 16;

    // Divider for t: magnitude numerator and quotient widths.
    localparam int TNUM_W  = COORD_W + 1 + FRAC_W;
    localparam int TQ_W    = COORD_W + 1;
    localparam int TDEN_W  = COORD_W;
    localparam int PNT_W   = COORD_W + FRAC_W + 1;

    // Pipeline stage numbers.
    localparam int ST_SEL   = 0;
    localparam int ST_MAG   = 1;
    localparam int ST_DIV0  = 2;
    localparam int ST_IVL   = ST_DIV0 + TQ_W;
    localparam int ST_MUL   = ST_IVL + 1;
    localparam int ST_PNT   = ST_MUL + 1;
    localparam int ST_BND   = ST_PNT + 1;
    localparam int ST_TEX0  = ST_BND + 1;
    localparam int ST_OUT   = ST_TEX0 + TEX_W;
    localparam int NUM_STG  = ST_OUT + 1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PLANE_AXIS   = 3'd0;
    localparam logic [2:0] CFG_PLANE_OFFSET = 3'd1;
    localparam logic [2:0] CFG_A_LOW        = 3'd2;
    localparam logic [2:0] CFG_A_HIGH       = 3'd3;
    localparam logic [2:0] CFG_B_LOW        = 3'd4;
    localparam logic [2:0] CFG_B_HIGH       = 3'd5;
    localparam logic [2:0] CFG_MATERIAL     = 3'd6;

    // Plane codes and normal axis codes.
    localparam logic [1:0] PLANE_XY = 2'd0;
    localparam logic [1:0] PLANE_XZ = 2'd1;
    localparam logic [1:0] PLANE_YZ = 2'd2;
    localparam logic [1:0] NORM_X   = 2'd0;
    localparam logic [1:0] NORM_Y   = 2'd1;
    localparam logic [1:0] NORM_Z   = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

endpackage

`default_nettype wire

// ===== design/arrh_tdiv.sv =====
// Pipelined restoring divider for the ray parameter, one quotient bit per stage.
// Depends on arrh_pkg; stage enables come from the top level's pipeline control.
`default_nettype none

module arrh_tdiv import arrh_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic [TQ_W-1:0]   i_adv,
    input  wire logic [TNUM_W-1:0] i_num,
    input  wire logic [TDEN_W-1:0] i_den,
    output logic      [TQ_W-1:0]   o_quo
);

    logic [TDEN_W-1:0] r_rem  [TQ_W];
    logic [TQ_W-1:0]   r_bits [TQ_W];
    logic [TQ_W-1:0]   r_quo  [TQ_W];
    logic [TDEN_W-1:0] r_den  [TQ_W];

    // One compare and subtract per stage on the running remainder.
    genvar k;
    generate
        for (k = 0; k < TQ_W; k++) begin : g_step
            logic [TDEN_W-1:0] rem_in;
            logic [TQ_W-1:0]   bits_in;
            logic [TQ_W-1:0]   quo_in;
            logic [TDEN_W-1:0] den_in;
            logic [TDEN_W:0]   trial;
            logic [TDEN_W:0]   diff;
            logic              ge;

            if (k == 0) begin : g_first
                assign rem_in  = TDEN_W'(i_num[TNUM_W-1:TQ_W]);
                assign bits_in = i_num[TQ_W-1:0];
                assign quo_in  = '0;
                assign den_in  = i_den;
            end else begin : g_next
                assign rem_in  = r_rem[k-1];
                assign bits_in = r_bits[k-1];
                assign quo_in  = r_quo[k-1];
                assign den_in  = r_den[k-1];
            end

            assign trial = {rem_in, bits_in[TQ_W-1]};
            assign diff  = trial - {1'b0, den_in};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (i_adv[k]) begin
                    r_rem[k]  <= ge ? diff[TDEN_W-1:0] : trial[TDEN_W-1:0];
                    r_bits[k] <= {bits_in[TQ_W-2:0], 1'b0};
                    r_quo[k]  <= {quo_in[TQ_W-2:0], ge};
                    r_den[k]  <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[TQ_W-1];

endmodule

`default_nettype wire

// ===== design/arrh_tex_div.sv =====
// Pipelined restoring divider for one texture coordinate, one bit per stage.
// Depends on arrh_pkg; computes (num * 2^FRAC_W) / den for num <= den.
`default_nettype none

module arrh_tex_div import arrh_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic [TEX_W-1:0]   i_adv,
    input  wire logic [COORD_W-1:0] i_num,
    input  wire logic [COORD_W-1:0] i_den,
    output logic      [TEX_W-1:0]   o_quo
);

    logic [COORD_W-1:0] r_rem  [TEX_W];
    logic [TEX_W-1:0]   r_bits [TEX_W];
    logic [TEX_W-1:0]   r_quo  [TEX_W];
    logic [COORD_W-1:0] r_den  [TEX_W];

    // The quotient never exceeds one, so it starts from num shifted right once.
    genvar k;
    generate
        for (k = 0; k < TEX_W; k++) begin : g_step
            logic [COORD_W-1:0] rem_in;
            logic [TEX_W-1:0]   bits_in;
            logic [TEX_W-1:0]   quo_in;
            logic [COORD_W-1:0] den_in;
            logic [COORD_W:0]   trial;
            logic [COORD_W:0]   diff;
            logic               ge;

            if (k == 0) begin : g_first
                assign rem_in  = {1'b0, i_num[COORD_W-1:1]};
                assign bits_in = {i_num[0], {(TEX_W-1){1'b0}}};
                assign quo_in  = '0;
                assign den_in  = i_den;
            end else begin : g_next
                assign rem_in  = r_rem[k-1];
                assign bits_in = r_bits[k-1];
                assign quo_in  = r_quo[k-1];
                assign den_in  = r_den[k-1];
            end

            assign trial = {rem_in, bits_in[TEX_W-1]};
            assign diff  = trial - {1'b0, den_in};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (i_adv[k]) begin
                    r_rem[k]  <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
                    r_bits[k] <= {bits_in[TEX_W-2:0], 1'b0};
                    r_quo[k]  <= {quo_in[TEX_W-2:0], ge};
                    r_den[k]  <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[TEX_W-1];

endmodule

`default_nettype wire

// ===== design/axis_rect_ray_hit.sv =====
// Ray against axis-aligned rectangle test, Q16.16 fixed point, fully pipelined.
// One ray enters per cycle unless every stage holds a ray and the output side stalls. The
// depth is set by the 33-stage divider that forms t and the two 17-stage dividers that form
// the texture coordinates. Every stage holds a valid bit, so an empty stage anywhere
// downstream lets a new ray in even while a result waits at the output. Configuration
// writes are taken at once and must only be issued while no ray is in flight.
`default_nettype none

module axis_rect_ray_hit import arrh_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write channel.
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [COORD_W-1:0] i_cfg_data,
    // Ray input channel.
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [COORD_W-1:0] i_origin_x,
    input  wire logic [COORD_W-1:0] i_origin_y,
    input  wire logic [COORD_W-1:0] i_origin_z,
    input  wire logic [COORD_W-1:0] i_dir_x,
    input  wire logic [COORD_W-1:0] i_dir_y,
    input  wire logic [COORD_W-1:0] i_dir_z,
    input  wire logic [COORD_W-1:0] i_t_min,
    input  wire logic [COORD_W-1:0] i_t_max,
    // Result channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_hit_flag,
    output logic [COORD_W-1:0]      o_hit_t,
    output logic [TEX_W-1:0]        o_tex_u,
    output logic [TEX_W-1:0]        o_tex_v,
    output logic [COORD_W-1:0]      o_point_x,
    output logic [COORD_W-1:0]      o_point_y,
    output logic [COORD_W-1:0]      o_point_z,
    output logic [1:0]              o_normal_axis,
    output logic [MAT_W-1:0]        o_hit_material
);

    typedef struct packed {
        t_coord ox;
        t_coord oy;
        t_coord oz;
        t_coord dx;
        t_coord dy;
        t_coord dz;
        t_coord tmin;
        t_coord tmax;
        logic   neg;
        logic   miss;
    } t_ray;

    typedef struct packed {
        t_coord px;
        t_coord py;
        t_coord pz;
        t_coord t;
        logic   miss;
    } t_hit;

    // Configuration registers.
    logic [1:0]       r_plane_axis;
    t_coord           r_plane_offset;
    t_coord           r_a_lo;
    t_coord           r_a_hi;
    t_coord           r_b_lo;
    t_coord           r_b_hi;
    logic [MAT_W-1:0] r_material;

    // Pipeline control.
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] adv;

    // Stage registers.
    t_ray                   r0_ray;
    logic signed [COORD_W:0] r0_num;
    t_coord                 r0_dn;
    t_ray                   r1_ray;
    logic [TNUM_W-1:0]      r1_num;
    logic [TDEN_W-1:0]      r1_den;
    t_ray                   r_dray [TQ_W];
    t_coord                 r4_o [3];
    t_coord                 r4_d [3];
    t_coord                 r4_t;
    logic                   r4_miss;
    t_coord                 r5_o [3];
    logic signed [2*COORD_W-1:0] r5_prod [3];
    t_coord                 r5_t;
    logic                   r5_miss;
    logic signed [PNT_W-1:0] r6_p [3];
    t_coord                 r6_t;
    logic                   r6_miss;
    t_hit                   r7_hit;
    logic [COORD_W-1:0]     r7_ca;
    logic [COORD_W-1:0]     r7_da;
    logic [COORD_W-1:0]     r7_cb;
    logic [COORD_W-1:0]     r7_db;
    t_hit                   r_thit [TEX_W];

    // Output registers.
    logic                   r_hit_flag;
    t_coord                 r_hit_t;
    logic [TEX_W-1:0]       r_tex_u;
    logic [TEX_W-1:0]       r_tex_v;
    t_coord                 r_point_x;
    t_coord                 r_point_y;
    t_coord                 r_point_z;
    logic [1:0]             r_normal_axis;
    logic [MAT_W-1:0]       r_hit_material;

    // Combinational helpers.
    logic [1:0]             sel_n;
    logic                   plane_bad;
    t_coord                 sel_o;
    t_coord                 sel_d;
    logic                   cfg_miss;
    logic [COORD_W:0]       num_mag;
    logic [TDEN_W-1:0]      den_mag;
    t_ray                   mag_ray;
    logic [TQ_W-1:0]        t_quo;
    logic signed [TQ_W:0]   t_full;
    logic                   t_in;
    logic signed [PNT_W-1:0] p_a;
    logic signed [PNT_W-1:0] p_b;
    logic                   bnd_in;
    logic [TEX_W-1:0]       quo_u;
    logic [TEX_W-1:0]       quo_v;

    // Clamp a wide point coordinate into the coordinate width.
    function automatic t_coord sat_c(input logic signed [PNT_W-1:0] v);
        t_coord res;
        if (&v[PNT_W-1:COORD_W-1] || ~|v[PNT_W-1:COORD_W-1]) begin
            res = v[COORD_W-1:0];
        end else if (v[PNT_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Configuration writes; indexes beyond the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_axis   <= PLANE_XY;
            r_plane_offset <= '0;
            r_a_lo         <= '0;
            r_a_hi         <= COORD_W'(1) << FRAC_W;
            r_b_lo         <= '0;
            r_b_hi         <= COORD_W'(1) << FRAC_W;
            r_material     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PLANE_AXIS:   r_plane_axis   <= i_cfg_data[1:0];
                CFG_PLANE_OFFSET: r_plane_offset <= i_cfg_data;
                CFG_A_LOW:        r_a_lo         <= i_cfg_data;
                CFG_A_HIGH:       r_a_hi         <= i_cfg_data;
                CFG_B_LOW:        r_b_lo         <= i_cfg_data;
                CFG_B_HIGH:       r_b_hi         <= i_cfg_data;
                CFG_MATERIAL:     r_material     <= i_cfg_data[MAT_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it or any stage after it has room, or when the output side is ready.
    genvar g;
    generate
        for (g = 0; g < NUM_STG; g++) begin : g_adv
            assign adv[g] = i_out_ready | ~(&r_vld[NUM_STG-1:g]);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[ST_OUT];

    // Normal axis and ray components along it, from the selected plane.
    always_comb begin
        plane_bad = 1'b0;
        case (r_plane_axis)
            PLANE_XY: begin
                sel_n = NORM_Z;
                sel_o = i_origin_z;
                sel_d = i_dir_z;
            end
            PLANE_XZ: begin
                sel_n = NORM_Y;
                sel_o = i_origin_y;
                sel_d = i_dir_y;
            end
            PLANE_YZ: begin
                sel_n = NORM_X;
                sel_o = i_origin_x;
                sel_d = i_dir_x;
            end
            default: begin
                sel_n     = NORM_X;
                sel_o     = i_origin_x;
                sel_d     = i_dir_x;
                plane_bad = 1'b1;
            end
        endcase
        cfg_miss = plane_bad || (r_a_hi <= r_a_lo) || (r_b_hi <= r_b_lo) ||
                   (sel_d == '0);
    end

    // Stage: capture the ray and form the distance to the plane.
    always_ff @(posedge i_clk) begin
        if (adv[ST_SEL]) begin
            r0_ray.ox   <= i_origin_x;
            r0_ray.oy   <= i_origin_y;
            r0_ray.oz   <= i_origin_z;
            r0_ray.dx   <= i_dir_x;
            r0_ray.dy   <= i_dir_y;
            r0_ray.dz   <= i_dir_z;
            r0_ray.tmin <= i_t_min;
            r0_ray.tmax <= i_t_max;
            r0_ray.neg  <= 1'b0;
            r0_ray.miss <= cfg_miss;
            r0_num      <= {r_plane_offset[COORD_W-1], r_plane_offset} -
                           {sel_o[COORD_W-1], sel_o};
            r0_dn       <= sel_d;
        end
    end

    // Stage: magnitudes for the divider and early overflow detection.
    always_comb begin
        num_mag      = r0_num[COORD_W] ? (COORD_W+1)'(-r0_num) : r0_num;
        den_mag      = r0_dn[COORD_W-1] ? TDEN_W'(-r0_dn) : r0_dn;
        mag_ray      = r0_ray;
        mag_ray.neg  = r0_num[COORD_W] ^ r0_dn[COORD_W-1];
        mag_ray.miss = r0_ray.miss ||
                       (TDEN_W'(num_mag[COORD_W:TQ_W-FRAC_W]) >= den_mag);
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_MAG]) begin
            r1_ray <= mag_ray;
            r1_num <= {num_mag, {FRAC_W{1'b0}}};
            r1_den <= den_mag;
        end
    end

    // Divider for t, with the ray fields riding alongside.
    arrh_tdiv u_tdiv (
        .i_clk (i_clk),
        .i_adv (adv[ST_DIV0 +: TQ_W]),
        .i_num (r1_num),
        .i_den (r1_den),
        .o_quo (t_quo)
    );

    always_ff @(posedge i_clk) begin
        if (adv[ST_DIV0]) begin
            r_dray[0] <= r1_ray;
        end
        for (int k = 1; k < TQ_W; k++) begin
            if (adv[ST_DIV0+k]) begin
                r_dray[k] <= r_dray[k-1];
            end
        end
    end

    // Stage: sign of t and the interval test.
    always_comb begin
        t_full = r_dray[TQ_W-1].neg ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});
        t_in   = (t_full >= $signed({{2{r_dray[TQ_W-1].tmin[COORD_W-1]}},
                                      r_dray[TQ_W-1].tmin})) &&
                 (t_full <= $signed({{2{r_dray[TQ_W-1].tmax[COORD_W-1]}},
                                      r_dray[TQ_W-1].tmax}));
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_IVL]) begin
            r4_o[0] <= r_dray[TQ_W-1].ox;
            r4_o[1] <= r_dray[TQ_W-1].oy;
            r4_o[2] <= r_dray[TQ_W-1].oz;
            r4_d[0] <= r_dray[TQ_W-1].dx;
            r4_d[1] <= r_dray[TQ_W-1].dy;
            r4_d[2] <= r_dray[TQ_W-1].dz;
            r4_t    <= t_full[COORD_W-1:0];
            r4_miss <= r_dray[TQ_W-1].miss || !t_in;
        end
    end

    // Stage: t times each direction component.
    always_ff @(posedge i_clk) begin
        if (adv[ST_MUL]) begin
            for (int i = 0; i < 3; i++) begin
                r5_prod[i] <= (2*COORD_W)'(r4_t) * (2*COORD_W)'(r4_d[i]);
                r5_o[i]    <= r4_o[i];
            end
            r5_t    <= r4_t;
            r5_miss <= r4_miss;
        end
    end

    // Stage: hit point, the product floored to whole fixed-point steps.
    always_ff @(posedge i_clk) begin
        if (adv[ST_PNT]) begin
            for (int i = 0; i < 3; i++) begin
                r6_p[i] <= $signed({{(PNT_W-COORD_W){r5_o[i][COORD_W-1]}}, r5_o[i]}) +
                           $signed({r5_prod[i][2*COORD_W-1], r5_prod[i][2*COORD_W-1:FRAC_W]});
            end
            r6_t    <= r5_t;
            r6_miss <= r5_miss;
        end
    end

    // Stage: bounds test on the two in-plane coordinates and texture setup.
    always_comb begin
        case (r_plane_axis)
            PLANE_XY: begin
                p_a = r6_p[0];
                p_b = r6_p[1];
            end
            PLANE_XZ: begin
                p_a = r6_p[0];
                p_b = r6_p[2];
            end
            default: begin
                p_a = r6_p[1];
                p_b = r6_p[2];
            end
        endcase
        bnd_in = (p_a >= $signed({{(PNT_W-COORD_W){r_a_lo[COORD_W-1]}}, r_a_lo})) &&
                 (p_a <= $signed({{(PNT_W-COORD_W){r_a_hi[COORD_W-1]}}, r_a_hi})) &&
                 (p_b >= $signed({{(PNT_W-COORD_W){r_b_lo[COORD_W-1]}}, r_b_lo})) &&
                 (p_b <= $signed({{(PNT_W-COORD_W){r_b_hi[COORD_W-1]}}, r_b_hi}));
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_BND]) begin
            r7_hit.px   <= sat_c(r6_p[0]);
            r7_hit.py   <= sat_c(r6_p[1]);
            r7_hit.pz   <= sat_c(r6_p[2]);
            r7_hit.t    <= r6_t;
            r7_hit.miss <= r6_miss || !bnd_in;
            r7_ca       <= p_a[COORD_W-1:0] - r_a_lo;
            r7_da       <= r_a_hi - r_a_lo;
            r7_cb       <= p_b[COORD_W-1:0] - r_b_lo;
            r7_db       <= r_b_hi - r_b_lo;
        end
    end

    // Texture coordinate dividers, with the hit fields riding alongside.
    arrh_tex_div u_div_u (
        .i_clk (i_clk),
        .i_adv (adv[ST_TEX0 +: TEX_W]),
        .i_num (r7_ca),
        .i_den (r7_da),
        .o_quo (quo_u)
    );

    arrh_tex_div u_div_v (
        .i_clk (i_clk),
        .i_adv (adv[ST_TEX0 +: TEX_W]),
        .i_num (r7_cb),
        .i_den (r7_db),
        .o_quo (quo_v)
    );

    always_ff @(posedge i_clk) begin
        if (adv[ST_TEX0]) begin
            r_thit[0] <= r7_hit;
        end
        for (int k = 1; k < TEX_W; k++) begin
            if (adv[ST_TEX0+k]) begin
                r_thit[k] <= r_thit[k-1];
            end
        end
    end

    // Output register; a miss reports every field as zero.
    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            if (r_thit[TEX_W-1].miss) begin
                r_hit_flag     <= 1'b0;
                r_hit_t        <= '0;
                r_tex_u        <= '0;
                r_tex_v        <= '0;
                r_point_x      <= '0;
                r_point_y      <= '0;
                r_point_z      <= '0;
                r_normal_axis  <= NORM_X;
                r_hit_material <= '0;
            end else begin
                r_hit_flag     <= 1'b1;
                r_hit_t        <= r_thit[TEX_W-1].t;
                r_tex_u        <= quo_u;
                r_tex_v        <= quo_v;
                r_point_x      <= r_thit[TEX_W-1].px;
                r_point_y      <= r_thit[TEX_W-1].py;
                r_point_z      <= r_thit[TEX_W-1].pz;
                r_normal_axis  <= sel_n;
                r_hit_material <= r_material;
            end
        end
    end

    assign o_hit_flag     = r_hit_flag;
    assign o_hit_t        = r_hit_t;
    assign o_tex_u        = r_tex_u;
    assign o_tex_v        = r_tex_v;
    assign o_point_x      = r_point_x;
    assign o_point_y      = r_point_y;
    assign o_point_z      = r_point_z;
    assign o_normal_axis  = r_normal_axis;
    assign o_hit_material = r_hit_material;

    // Checks on the pipeline and the result encoding.
    `include "axis_rect_ray_hit_macros.svh"

    `ARRH_ASSERT_IMP(a_miss_zero, o_out_valid && !o_hit_flag, o_hit_t == '0 && o_tex_u == '0 && o_tex_v == '0 && o_point_x == '0 && o_hit_material == '0)
    `ARRH_ASSERT_IMP(a_tex_range, o_out_valid && o_hit_flag, o_tex_u <= (TEX_W'(1) << FRAC_W) && o_tex_v <= (TEX_W'(1) << FRAC_W))
    `ARRH_ASSERT_IMP(a_hit_normal, o_out_valid && o_hit_flag, o_normal_axis == sel_n)
    `ARRH_ASSERT_NXT(a_accept_fills, i_in_valid && o_in_ready, r_vld[ST_SEL])

endmodule

`default_nettype wire

// ===== tb/tb_axis_rect_ray_hit.sv =====
// Testbench for axis_rect_ray_hit: rays are streamed under several rectangle settings.
// Results are checked against a fixed point predictor kept inside this file or typed expectations.
// Depends on arrh_pkg and the axis_rect_ray_hit RTL only.
`timescale 1ns / 1ps

module tb_axis_rect_ray_hit;
    import arrh_pkg::*;

    typedef struct packed {
        t_coord ox, oy, oz, dx, dy, dz, tmin, tmax;
    } t_ray_in;

    typedef struct packed {
        logic             flag;
        logic [COORD_W-1:0] t;
        logic [TEX_W-1:0]   u, v;
        logic [COORD_W-1:0] px, py, pz;
        logic [1:0]         norm;
        logic [MAT_W-1:0]   mat;
    } t_res;

    typedef enum logic { CHK_MODEL, CHK_TYPED } t_chk;

    typedef struct {
        t_ray_in ray;
        t_chk    chk;
        t_res    res;
    } t_row;

    typedef struct {
        logic [1:0] axis;
        longint     off, alow, ahigh, blow, bhigh;
        logic [15:0] mat;
    } t_rect_cfg;

    localparam longint ONE  = 64'sd1 << FRAC_W;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam int WATCH_LIMIT = 4000;
    localparam int NUM_RAND = 1750;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    t_ray_in            in_ray = '0;
    logic               out_ready = 1'b0;
    wire                o_cfg_ready, o_in_ready, o_out_valid;
    t_res               got;

    // Predictor copy of the registers.
    logic [1:0]  rect_axis;
    longint      rect_off, rect_alow, rect_ahigh, rect_blow, rect_bhigh;
    logic [15:0] rect_mat;

    t_res pending_hits[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   no_idle = 1'b0;
    int   out_stall = 0;

    axis_rect_ray_hit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_origin_x(in_ray.ox), .i_origin_y(in_ray.oy), .i_origin_z(in_ray.oz),
        .i_dir_x(in_ray.dx), .i_dir_y(in_ray.dy), .i_dir_z(in_ray.dz),
        .i_t_min(in_ray.tmin), .i_t_max(in_ray.tmax),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_hit_flag(got.flag), .o_hit_t(got.t), .o_tex_u(got.u), .o_tex_v(got.v),
        .o_point_x(got.px), .o_point_y(got.py), .o_point_z(got.pz),
        .o_normal_axis(got.norm), .o_hit_material(got.mat)
    );

    // Clock generation.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [COORD_W-1:0] sat_coord(input longint v);
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return v[COORD_W-1:0];
    endfunction

    // Expected result of one ray under the current rectangle.
    function automatic t_res ray_hit(input t_ray_in r);
        longint o[3], d[3], p[3];
        longint t;
        int n, ia, ib;
        t_res e;
        e = '0;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        case (rect_axis)
            PLANE_XY: begin n = 2; ia = 0; ib = 1; end
            PLANE_XZ: begin n = 1; ia = 0; ib = 2; end
            PLANE_YZ: begin n = 0; ia = 1; ib = 2; end
            default: return e;
        endcase
        if (d[n] == 0) return e;
        if (rect_ahigh <= rect_alow || rect_bhigh <= rect_blow) return e;
        t = ((rect_off - o[n]) * ONE) / d[n];
        if (t < longint'(r.tmin) || t > longint'(r.tmax)) return e;
        for (int i = 0; i < 3; i++) p[i] = o[i] + ((t * d[i]) >>> FRAC_W);
        if (p[ia] < rect_alow || p[ia] > rect_ahigh || p[ib] < rect_blow || p[ib] > rect_bhigh)
            return e;
        e.flag = 1'b1;
        e.t    = sat_coord(t);
        e.u    = TEX_W'(((p[ia] - rect_alow) <<< 16) / (rect_ahigh - rect_alow));
        e.v    = TEX_W'(((p[ib] - rect_blow) <<< 16) / (rect_bhigh - rect_blow));
        e.px   = sat_coord(p[0]);
        e.py   = sat_coord(p[1]);
        e.pz   = sat_coord(p[2]);
        e.norm = 2'(n);
        e.mat  = rect_mat;
        return e;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    // Result side: random stall per item, compare against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item: %p", got);
            end else begin
                t_res e;
                e = pending_hits.pop_front();
                if (e !== got) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %p", e);
                        $display("          actual   %p", got);
                    end
                end
            end
            out_stall = draw_gap();
        end else if (out_stall > 0) begin
            out_stall--;
        end
        out_ready <= i_rst_n && (out_stall == 0);
    end

    // Watchdog on cycles with no item moving on any channel.
    always @(posedge i_clk) begin
        if ((o_out_valid && out_ready) || (in_valid && o_in_ready) || (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("FAIL axis_rect_ray_hit");
            $finish;
        end
    end

    task automatic send_ray(input t_ray_in r, input t_chk chk, input t_res typed);
        int   gap;
        t_res exp_res;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_ray   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        exp_res = (chk == CHK_TYPED) ? typed : ray_hit(r);
        pending_hits = {pending_hits, exp_res};
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PLANE_AXIS:   rect_axis  = val[1:0];
            CFG_PLANE_OFFSET: rect_off   = t_coord'(val);
            CFG_A_LOW:        rect_alow  = t_coord'(val);
            CFG_A_HIGH:       rect_ahigh = t_coord'(val);
            CFG_B_LOW:        rect_blow  = t_coord'(val);
            CFG_B_HIGH:       rect_bhigh = t_coord'(val);
            CFG_MATERIAL:     rect_mat   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic longint rand_span(input longint lo, input longint hi);
        longint span;
        span = hi - lo + 1;
        if (span <= 0) return lo;
        return lo + longint'({1'b0, $urandom, $urandom} % span);
    endfunction

    function automatic t_coord clip(input longint v);
        return t_coord'(sat_coord(v));
    endfunction

    // A ray aimed at a point of the current rectangle, with random content.
    function automatic t_ray_in aimed_ray();
        longint t, tgt[3], d[3], o[3], alo, ahi, blo, bhi;
        int n, ia, ib;
        t_ray_in r;
        case (rect_axis)
            PLANE_XZ: begin n = 1; ia = 0; ib = 2; end
            PLANE_YZ: begin n = 0; ia = 1; ib = 2; end
            default:  begin n = 2; ia = 0; ib = 1; end
        endcase
        alo = rect_alow; ahi = rect_ahigh; blo = rect_blow; bhi = rect_bhigh;
        if (ahi < alo) begin alo = rect_ahigh; ahi = rect_alow; end
        if (bhi < blo) begin blo = rect_bhigh; bhi = rect_blow; end
        tgt[n]  = rect_off;
        tgt[ia] = ($urandom_range(0, 7) == 0) ? (($urandom & 1) ? ahi : alo) : rand_span(alo, ahi);
        tgt[ib] = ($urandom_range(0, 7) == 0) ? (($urandom & 1) ? bhi : blo) : rand_span(blo, bhi);
        t = $urandom_range(1, 1 << 20);
        for (int i = 0; i < 3; i++) begin
            d[i] = rand_span(-(64'sd1 << 18), 64'sd1 << 18);
            if (d[i] == 0) d[i] = 1;
            o[i] = clip(tgt[i] - ((t * d[i]) >>> FRAC_W));
        end
        r.ox = o[0]; r.oy = o[1]; r.oz = o[2];
        r.dx = d[0]; r.dy = d[1]; r.dz = d[2];
        case ($urandom_range(0, 5))
            0: begin r.tmin = t; r.tmax = t; end
            1: begin r.tmin = t + 1; r.tmax = t + $urandom_range(1, 100); end
            2: begin r.tmin = t + 50; r.tmax = t - 50; end
            default: begin
                r.tmin = t - $urandom_range(0, 4096);
                r.tmax = t + $urandom_range(0, 4096);
            end
        endcase
        return r;
    endfunction

    task automatic load_rect(input t_rect_cfg c);
        write_reg(CFG_PLANE_AXIS, {30'd0, c.axis});
        write_reg(CFG_PLANE_OFFSET, c.off[31:0]);
        write_reg(CFG_A_LOW, c.alow[31:0]);
        write_reg(CFG_A_HIGH, c.ahigh[31:0]);
        write_reg(CFG_B_LOW, c.blow[31:0]);
        write_reg(CFG_B_HIGH, c.bhigh[31:0]);
        write_reg(CFG_MATERIAL, {16'd0, c.mat});
    endtask

    // Stimulus and the final verdict.
    initial begin
        t_row      rows[$];
        t_row      rw;
        t_rect_cfg settings[$];
        t_rect_cfg c;
        t_ray_in   r;
        int        per_phase;

        rect_axis = PLANE_XY; rect_off = 0; rect_mat = 0;
        rect_alow = 0; rect_ahigh = ONE; rect_blow = 0; rect_bhigh = ONE;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rays against the unit square at z = 0 after reset.
        rw.chk = CHK_TYPED;
        rw.ray = '{32'sh8000, 32'sh8000, 32'sh10000, 0, 0, -32'sh10000, 0, 32'sh20000};
        rw.res = '{1'b1, 32'h10000, 17'h8000, 17'h8000, 32'h8000, 32'h8000, 32'h0,
                   NORM_Z, 16'h0};
        rows = {rows, rw};
        rw.res = '0;
        // Zero direction along the normal.
        rw.ray.dz = 0;
        rows = {rows, rw};
        // Empty interval.
        rw.ray = '{32'sh8000, 32'sh8000, 32'sh10000, 0, 0, -32'sh10000, 32'sh20000, 0};
        rows = {rows, rw};
        // Hit lies past t_max.
        rw.ray = '{32'sh8000, 32'sh8000, 32'sh10000, 0, 0, -32'sh10000, 0, 32'shFFFF};
        rows = {rows, rw};
        // Misses the square sideways.
        rw.ray = '{32'sh30000, 32'sh8000, 32'sh10000, 0, 0, -32'sh10000, 0, 32'sh20000};
        rows = {rows, rw};
        rw.chk = CHK_MODEL;
        // Corner hits, bounds inclusive, and an interior hit.
        rw.ray = '{0, 0, 32'sh10000, 0, 0, -32'sh10000, CMIN, CMAX};
        rows = {rows, rw};
        rw.ray = '{32'sh10000, 32'sh10000, -32'sh10000, 0, 0, 32'sh10000, CMIN, CMAX};
        rows = {rows, rw};
        rw.ray = '{32'sh4000, 32'shC000, 32'sh20000, 32'sh2000, -32'sh1000, -32'sh8000,
                   0, CMAX};
        rows = {rows, rw};
        // Field extremes.
        rw.ray = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX};
        rows = {rows, rw};
        rw.ray = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN};
        rows = {rows, rw};
        rw.ray = '{0, 0, CMAX, 0, 0, CMIN, CMIN, CMAX};
        rows = {rows, rw};
        rw.ray = '{0, 0, CMIN, 1, -1, 1, CMIN, CMAX};
        rows = {rows, rw};
        rw.ray = '{32'sh8000, 32'sh8000, 1, CMIN, CMAX, -1, CMIN, CMAX};
        rows = {rows, rw};
        rw.ray = '{0, 0, 0, 0, 0, 0, 0, 0};
        rows = {rows, rw};
        rw.ray = '{-1, -1, -1, -1, -1, -1, -1, -1};
        rows = {rows, rw};
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].chk, rows[i].res);
        wait_drained();

        // Rectangle settings walked by the random part.
        c = '{PLANE_XY, 0, 0, ONE, 0, ONE, 16'h0001};
        settings = {settings, c};
        c = '{PLANE_XZ, -5 * ONE, -3 * ONE, 2 * ONE, -ONE, 4 * ONE, 16'hA5A5};
        settings = {settings, c};
        c = '{PLANE_YZ, 7 * ONE, -8 * ONE, -2 * ONE, 3 * ONE, 9 * ONE, 16'h5A5A};
        settings = {settings, c};
        c = '{PLANE_XY, CMAX, CMIN, CMAX, CMIN, CMAX, 16'hFFFF};
        settings = {settings, c};
        c = '{PLANE_XZ, CMIN, CMIN, CMIN + 1, CMAX - 1, CMAX, 16'h8000};
        settings = {settings, c};
        c = '{PLANE_YZ, 0, ONE, ONE, 0, ONE, 16'h1234};
        settings = {settings, c};
        c = '{PLANE_XY, ONE, 0, ONE, 2 * ONE, -ONE, 16'h4321};
        settings = {settings, c};
        c = '{2'd3, 0, 0, ONE, 0, ONE, 16'h7777};
        settings = {settings, c};
        c = '{PLANE_YZ, -ONE / 2, -ONE, ONE, -ONE, ONE, 16'h0000};
        settings = {settings, c};
        per_phase = NUM_RAND / settings.size();

        foreach (settings[s]) begin
            c = settings[s];
            wait_drained();
            load_rect(c);
            if (s == 2) write_reg(3'd7, $urandom);
            no_idle = (s == 4);
            for (int k = 0; k < per_phase; k++) begin
                if (k == per_phase / 2 && s == 1) wait_drained();
                if ($urandom_range(0, 99) < 75) begin
                    r = aimed_ray();
                end else begin
                    r = {$urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom};
                end
                send_ray(r, CHK_MODEL, '0);
            end
        end
        no_idle = 1'b0;

        // Drain and let any stray result show up.
        wait_drained();
        repeat (NUM_STG + 20) @(posedge i_clk);
        mismatches += pending_hits.size();
        if (mismatches == 0) begin
            $display("PASS axis_rect_ray_hit");
        end else begin
            $display("FAIL axis_rect_ray_hit");
        end
        $finish;
    end

endmodule
